[design/homogeneous_point_vector_transform_unit_assert.svh]
`ifndef HOMOGENEOUS_POINT_VECTOR_TRANSFORM_UNIT_ASSERT_SVH
`define HOMOGENEOUS_POINT_VECTOR_TRANSFORM_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define HPVT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hpvt check failed");

// Check that a condition implies a consequence in the next cycle.
`define HPVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hpvt check failed");

// Check the state in the cycle after reset is seen.
`define HPVT_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("hpvt reset check failed");

`endif

[design/hpvt_pkg.sv]
package hpvt_pkg;

   localparam int CW      = 32;            // coordinate width
   localparam int FRAC    = 16;            // fraction bits
   localparam int PROD_W  = 2 * CW;        // exact product
   localparam int OFF_W   = CW + FRAC;     // translation term at 2*FRAC fraction bits
   localparam int SUM_W   = PROD_W + 2;    // three products plus offset
   localparam int RES_W   = SUM_W - FRAC;  // sum after the shift
   localparam int ABS_W   = RES_W;         // magnitude of a shifted sum
   localparam int QUO_W   = CW - 1;        // quotient bits below saturation
   localparam int STEPS   = QUO_W;         // one quotient bit per divider stage
   localparam int SAT_SH  = CW - 1 - FRAC; // integer bits left before saturation
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);

   localparam logic signed [CW-1:0] ONE_Q = CW'(1) << FRAC;
   localparam logic signed [CW-1:0] MAX_Q = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] MIN_Q = {1'b1, {(CW-1){1'b0}}};

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_POINT  = 2'd1;
   localparam logic [1:0] CMD_VECTOR = 2'd2;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_SAT    = 2'd1;
   localparam logic [1:0] STATUS_ZERO_W = 2'd2;
   localparam logic [1:0] STATUS_UNUSED = 2'd3;

   // One transform, summed and shifted, on its way to the back end.
   typedef struct packed {
      logic                          point;
      logic                          proj;
      logic [2:0][RES_W-1:0]         r;
      logic [RES_W-1:0]              w;
   } front_item_type;

endpackage

[design/hpvt_queue.sv]
module hpvt_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_push,
   input  hpvt_pkg::front_item_type q_wdata,
   output logic                     q_full,
   input  logic                     q_pop,
   output hpvt_pkg::front_item_type q_head,
   output logic                     q_empty
);

   hpvt_pkg::front_item_type       mem_ff [hpvt_pkg::QDEPTH];
   logic [hpvt_pkg::QPTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [hpvt_pkg::QPTR_W:0]      cnt_ff, cnt_in;
   logic                           do_push, do_pop;

   assign q_full  = (cnt_ff == (hpvt_pkg::QPTR_W+1)'(hpvt_pkg::QDEPTH));
   assign q_empty = (cnt_ff == '0);
   assign q_head  = mem_ff[rd_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (hpvt_pkg::QPTR_W+1)'(do_push) - (hpvt_pkg::QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= q_wdata;
      end
   end

endmodule

[design/hpvt_front.sv]
module hpvt_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [1:0]               req_cmd,
   input  logic [3:0]               req_coef_index,
   input  logic signed [31:0]       req_coef_value,
   input  logic signed [31:0]       req_in_x,
   input  logic signed [31:0]       req_in_y,
   input  logic signed [31:0]       req_in_z,
   output logic                     q_push,
   output hpvt_pkg::front_item_type q_wdata,
   input  logic                     q_full
);

   logic signed [hpvt_pkg::CW-1:0]     m_ff [16];
   logic                               a_valid_ff, a_valid_in;
   logic                               a_point_ff, a_proj_ff;
   logic signed [hpvt_pkg::PROD_W-1:0] p_ff [4][3];
   logic signed [hpvt_pkg::OFF_W-1:0]  off_ff [4];
   logic                               adv, accept, is_xform, is_point, affine;
   logic signed [hpvt_pkg::SUM_W-1:0]  sum [4];

   // Advance unless the held transform cannot enter the queue.
   assign adv      = !(a_valid_ff && q_full);
   assign full     = !adv;
   assign accept   = push && adv;
   assign is_point = (req_cmd == hpvt_pkg::CMD_POINT);
   assign is_xform = is_point || (req_cmd == hpvt_pkg::CMD_VECTOR);
   assign affine   = (m_ff[3] == '0) && (m_ff[7] == '0) && (m_ff[11] == '0)
                     && (m_ff[15] == hpvt_pkg::ONE_Q);
   assign a_valid_in = accept && is_xform;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            m_ff[i] <= (i % 5 == 0) ? hpvt_pkg::ONE_Q : '0;
         end
      end else if (accept && req_cmd == hpvt_pkg::CMD_LOAD) begin
         m_ff[req_coef_index] <= req_coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= a_valid_in;
      end
   end

   // Column j of the matrix: x*M[j] + y*M[4+j] + z*M[8+j] + offset.
   always_ff @(posedge clock) begin
      if (adv) begin
         a_point_ff <= is_point;
         a_proj_ff  <= is_point && !affine;
         for (int j = 0; j < 4; j++) begin
            p_ff[j][0] <= req_in_x * m_ff[j];
            p_ff[j][1] <= req_in_y * m_ff[4+j];
            p_ff[j][2] <= req_in_z * m_ff[8+j];
            off_ff[j]  <= (is_point || j == 3) ?
                          {m_ff[12+j], {hpvt_pkg::FRAC{1'b0}}} : '0;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sum[j] = hpvt_pkg::SUM_W'(p_ff[j][0]) + hpvt_pkg::SUM_W'(p_ff[j][1])
                + hpvt_pkg::SUM_W'(p_ff[j][2]) + hpvt_pkg::SUM_W'(off_ff[j]);
      end
      q_wdata.point = a_point_ff;
      q_wdata.proj  = a_proj_ff;
      for (int j = 0; j < 3; j++) begin
         q_wdata.r[j] = sum[j][hpvt_pkg::SUM_W-1:hpvt_pkg::FRAC];
      end
      q_wdata.w = sum[3][hpvt_pkg::SUM_W-1:hpvt_pkg::FRAC];
   end

   assign q_push = a_valid_ff;

endmodule

[design/hpvt_back.sv]
module hpvt_back (
   input  logic                     clock,
   input  logic                     reset,
   input  hpvt_pkg::front_item_type q_head,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic                     empty,
   input  logic                     pop,
   output logic signed [31:0]       rsp_out_x,
   output logic signed [31:0]       rsp_out_y,
   output logic signed [31:0]       rsp_out_z,
   output logic [1:0]               rsp_status,
   output logic                     rsp_was_point
);

   typedef struct packed {
      logic                                  valid;
      logic                                  point;
      logic                                  proj;
      logic                                  zero_w;
      logic                                  clamp_sat;
      logic [2:0]                            sat;
      logic [2:0]                            neg;
      logic [hpvt_pkg::ABS_W-1:0]            den;
      logic [2:0][hpvt_pkg::ABS_W-1:0]       rem;
      logic [2:0][hpvt_pkg::QUO_W-1:0]       low;
      logic [2:0][hpvt_pkg::QUO_W-1:0]       quo;
      logic [2:0][hpvt_pkg::CW-1:0]          res;
   } div_stage_type;

   typedef struct packed {
      logic [2:0][hpvt_pkg::CW-1:0] xyz;
      logic [1:0]                   status;
      logic                         point;
   } rsp_item_type;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type               o;
      logic [hpvt_pkg::ABS_W:0]    t;
      o = s;
      for (int j = 0; j < 3; j++) begin
         t = {s.rem[j], s.low[j][hpvt_pkg::QUO_W-1]};
         if (t >= {1'b0, s.den}) begin
            o.rem[j] = hpvt_pkg::ABS_W'(t - {1'b0, s.den});
            o.quo[j] = {s.quo[j][hpvt_pkg::QUO_W-2:0], 1'b1};
         end else begin
            o.rem[j] = t[hpvt_pkg::ABS_W-1:0];
            o.quo[j] = {s.quo[j][hpvt_pkg::QUO_W-2:0], 1'b0};
         end
         o.low[j] = {s.low[j][hpvt_pkg::QUO_W-2:0], 1'b0};
      end
      return o;
   endfunction

   div_stage_type               s_ff [hpvt_pkg::STEPS+1];
   div_stage_type               entry;
   div_stage_type               last;
   rsp_item_type                ob_ff [2];
   rsp_item_type                fin;
   logic                        wr_ff, rd_ff;
   logic [1:0]                  cnt_ff;
   logic                        adv, ob_push, ob_pop;
   logic [hpvt_pkg::ABS_W-1:0]  absw;
   logic [hpvt_pkg::ABS_W-1:0]  absn [3];
   logic signed [hpvt_pkg::RES_W-1:0] n;

   assign last    = s_ff[hpvt_pkg::STEPS];
   assign adv     = !(last.valid && cnt_ff == 2'd2);
   assign q_pop   = adv && !q_empty;
   assign ob_push = adv && last.valid;
   assign ob_pop  = pop && !empty;
   assign empty   = (cnt_ff == 2'd0);

   always_comb begin
      absw = q_head.w[hpvt_pkg::RES_W-1] ? hpvt_pkg::ABS_W'(-q_head.w)
                                         : hpvt_pkg::ABS_W'(q_head.w);
      entry           = '0;
      entry.valid     = !q_empty;
      entry.point     = q_head.point;
      entry.proj      = q_head.proj;
      entry.zero_w    = q_head.proj && (q_head.w == '0);
      entry.den       = absw;
      entry.clamp_sat = 1'b0;
      n               = '0;
      for (int j = 0; j < 3; j++) begin
         n = q_head.r[j];
         absn[j] = n[hpvt_pkg::RES_W-1] ? hpvt_pkg::ABS_W'(-n) : hpvt_pkg::ABS_W'(n);
         entry.neg[j] = n[hpvt_pkg::RES_W-1] ^ q_head.w[hpvt_pkg::RES_W-1];
         // quotient of |n| << FRAC by |w| would reach 2^(CW-1)
         entry.sat[j] = {{hpvt_pkg::SAT_SH{1'b0}}, absn[j]}
                        >= {absw, {hpvt_pkg::SAT_SH{1'b0}}};
         entry.rem[j] = hpvt_pkg::ABS_W'(absn[j][hpvt_pkg::ABS_W-1:hpvt_pkg::SAT_SH]);
         entry.low[j] = {absn[j][hpvt_pkg::SAT_SH-1:0], {hpvt_pkg::FRAC{1'b0}}};
         if ((&n[hpvt_pkg::RES_W-1:hpvt_pkg::CW-1]) || !(|n[hpvt_pkg::RES_W-1:hpvt_pkg::CW-1]))
         begin
            entry.res[j] = n[hpvt_pkg::CW-1:0];
         end else begin
            entry.res[j] = n[hpvt_pkg::RES_W-1] ? hpvt_pkg::MIN_Q : hpvt_pkg::MAX_Q;
            entry.clamp_sat = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= hpvt_pkg::STEPS; k++) begin
            s_ff[k].valid <= 1'b0;
         end
      end else if (adv) begin
         s_ff[0] <= entry;
         for (int k = 0; k < hpvt_pkg::STEPS; k++) begin
            s_ff[k+1] <= div_step(s_ff[k]);
         end
      end
   end

   always_comb begin
      fin.point  = last.point;
      fin.status = hpvt_pkg::STATUS_OK;
      fin.xyz    = last.res;
      if (last.proj) begin
         if (last.zero_w) begin
            fin.xyz    = '0;
            fin.status = hpvt_pkg::STATUS_ZERO_W;
         end else begin
            for (int j = 0; j < 3; j++) begin
               if (last.sat[j]) begin
                  fin.xyz[j] = last.neg[j] ? hpvt_pkg::MIN_Q : hpvt_pkg::MAX_Q;
               end else if (last.neg[j]) begin
                  fin.xyz[j] = hpvt_pkg::CW'(0) - {1'b0, last.quo[j]};
               end else begin
                  fin.xyz[j] = {1'b0, last.quo[j]};
               end
            end
            if (|last.sat) begin
               fin.status = hpvt_pkg::STATUS_SAT;
            end
         end
      end else if (last.clamp_sat) begin
         fin.status = hpvt_pkg::STATUS_SAT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (ob_push) begin
            wr_ff <= !wr_ff;
         end
         if (ob_pop) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(ob_push) - 2'(ob_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (ob_push) begin
         ob_ff[wr_ff] <= fin;
      end
   end

   assign rsp_out_x     = ob_ff[rd_ff].xyz[0];
   assign rsp_out_y     = ob_ff[rd_ff].xyz[1];
   assign rsp_out_z     = ob_ff[rd_ff].xyz[2];
   assign rsp_status    = ob_ff[rd_ff].status;
   assign rsp_was_point = ob_ff[rd_ff].point;

endmodule

[design/homogeneous_point_vector_transform_unit.sv]
// Homogeneous 4x4 point and vector transform, Q16.16. The matrix is held in
// row-vector form, resets to identity, and is loaded one coefficient per load
// command (no result). A point item yields x*M11+y*M21+z*M31+M41 per column,
// divided by w when the last column is not (0,0,0,1); a vector item uses the
// upper 3x3 part only. Results saturate with status 1; a zero w gives zeros
// with status 2. One item is taken per cycle while full is low. A result passes
// the product registers, the queue, the divider pipeline, which resolves one
// quotient bit per stage for all three coordinates, and the result buffer
// before it shows on the ports.
// A load takes effect for every item accepted after it; items in flight
// already carry their products. Command code 3 is dropped.
module homogeneous_point_vector_transform_unit (
   input  logic               clock,
   input  logic               reset,
   // input queue side
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_cmd,
   input  logic [3:0]         req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic signed [31:0] req_in_z,
   // result queue side
   output logic               empty,
   input  logic               pop,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic [1:0]         rsp_status,
   output logic               rsp_was_point
);

   hpvt_pkg::front_item_type q_wdata, q_head;
   logic                     q_push, q_full, q_pop, q_empty;

   // Front: matrix store, multipliers, column sums.
   hpvt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_cmd        (req_cmd),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_in_x       (req_in_x),
      .req_in_y       (req_in_y),
      .req_in_z       (req_in_z),
      .q_push         (q_push),
      .q_wdata        (q_wdata),
      .q_full         (q_full)
   );

   // Decouple the two halves so each can stall on its own.
   hpvt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_empty (q_empty)
   );

   // Back: projective divide, saturation, result buffer.
   hpvt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_status    (rsp_status),
      .rsp_was_point (rsp_was_point)
   );

endmodule

[design/hpvt_checker.sv]
`include "homogeneous_point_vector_transform_unit_assert.svh"

module hpvt_checker (
   input logic               clock,
   input logic               reset,
   input logic               push,
   input logic               full,
   input logic [1:0]         req_cmd,
   input logic [3:0]         req_coef_index,
   input logic signed [31:0] req_coef_value,
   input logic signed [31:0] req_in_x,
   input logic signed [31:0] req_in_y,
   input logic signed [31:0] req_in_z,
   input logic               empty,
   input logic               pop,
   input logic signed [31:0] rsp_out_x,
   input logic signed [31:0] rsp_out_y,
   input logic signed [31:0] rsp_out_z,
   input logic [1:0]         rsp_status,
   input logic               rsp_was_point
);

   `HPVT_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, empty && !full)

   `HPVT_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_status))

   `HPVT_ASSERT_NOW(a_status_code, clock, reset, !empty, rsp_status != hpvt_pkg::STATUS_UNUSED)

   `HPVT_ASSERT_NOW(a_zero_w, clock, reset, !empty && rsp_status == hpvt_pkg::STATUS_ZERO_W, rsp_was_point && rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0)

endmodule

bind homogeneous_point_vector_transform_unit hpvt_checker u_checker (.*);
